FILE: hw/rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // operation codes carried in the kind field
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // register index decoded from paddr
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] min_value;
    } out_item_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic insert;   // accepted insert that is not refused
        logic extract;  // accepted extract on a non-empty queue
        logic valid;    // cell holds a stored entry
        logic tail;     // cell is the first free slot
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/mpq_cell.sv
`timescale 1ns / 1ps

module mpq_cell (
    input  logic                                    clk,
    input  mpq_pkg::cell_ctrl_t                     ctrl,
    input  logic signed [mpq_pkg::DATA_W-1:0]       new_value,
    input  logic signed [mpq_pkg::DATA_W-1:0]       left_value,
    input  logic                                    left_gt,
    input  logic signed [mpq_pkg::DATA_W-1:0]       right_value,
    output logic signed [mpq_pkg::DATA_W-1:0]       value,
    output logic                                    gt
);

    logic signed [mpq_pkg::DATA_W-1:0] value_reg;
    logic signed [mpq_pkg::DATA_W-1:0] value_next;

    // stored entry ranks after the incoming one; equal values stay ahead
    assign gt = ctrl.valid && (value_reg > new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.extract)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && (gt || ctrl.tail))
        begin
            // take the left neighbor when it moves right, else the new value
            value_next = left_gt ? left_value : new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hw/rtl/min_priority_queue.sv
`timescale 1ns / 1ps

// min_priority_queue: priority queue of signed 32-bit values, smallest first
//
// - input transaction: start high while busy is low; in_item.kind selects
//   insert (value is stored) or extract (value is ignored)
// - every accepted transaction gives exactly one result, shown on result
//   for one cycle with done high, in the cycle after acceptance
// - throughput: one transaction per cycle; busy is never raised, since each
//   cell of the sorted chain settles its next entry within the same cycle
// - entries sit in a chain of cells kept in ascending order; ties keep
//   arrival order, so the oldest of equal values leaves first
// - insert: every cell holding a larger value moves one place right and the
//   new value drops into the gap; a full queue answers overflow
// - extract: cell 0 is the minimum and the whole chain moves left by one;
//   an empty queue answers underflow with min_value zero
// - capacity register (APB, byte address 0) caps the fill level at
//   min(capacity, 64); write it only while no transaction is in flight
// - reset empties the queue, sets capacity to 64; no clearing pass needed
// - the receiver cannot hold results off, so no result ever waits

module min_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mpq_pkg::in_item_t                   in_item,
    output logic                                done,
    output mpq_pkg::out_item_t                  result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpq_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DEPTH = mpq_pkg::DEPTH;
    localparam int CNT_W = mpq_pkg::CNT_W;

    logic [CNT_W-1:0]              occ_reg;
    logic [CNT_W-1:0]              occ_next;
    logic [mpq_pkg::CAP_W-1:0]     capacity_reg;
    logic                          done_reg;
    mpq_pkg::out_item_t            result_reg;
    mpq_pkg::out_item_t            result_next;

    logic accept;
    logic cfg_write;
    logic is_insert;
    logic is_extract;
    logic full;
    logic empty;
    logic do_insert;
    logic do_extract;

    logic signed [mpq_pkg::DATA_W-1:0] cell_value [DEPTH];
    logic                              cell_gt    [DEPTH];

    // one transaction per cycle, never stalled
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_insert  = (in_item.kind == mpq_pkg::KIND_INSERT);
    assign is_extract = (in_item.kind == mpq_pkg::KIND_EXTRACT);

    // fill limit is min(capacity, DEPTH)
    assign full  = (32'(occ_reg) >= 32'(capacity_reg)) || (32'(occ_reg) >= 32'(DEPTH));
    assign empty = (occ_reg == '0);

    assign do_insert  = accept && is_insert && !full;
    assign do_extract = accept && is_extract && !empty;

    // chain of cells, cell 0 holds the minimum
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mpq_pkg::cell_ctrl_t               ctrl;
        logic signed [mpq_pkg::DATA_W-1:0] left_value;
        logic                              left_gt;
        logic signed [mpq_pkg::DATA_W-1:0] right_value;

        assign ctrl.insert  = do_insert;
        assign ctrl.extract = do_extract;
        assign ctrl.valid   = (occ_reg > CNT_W'(i));
        assign ctrl.tail    = (occ_reg == CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_value = in_item.value;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        // last cell shifts in its own value; it leaves the valid range anyway
        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        mpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (in_item.value),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    // occupancy and result
    always_comb
    begin
        occ_next = occ_reg;
        if (do_insert)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (do_extract)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end

        result_next.status    = mpq_pkg::STATUS_OK;
        result_next.min_value = '0;
        if (is_insert)
        begin
            if (full)
            begin
                result_next.status = mpq_pkg::STATUS_OVERFLOW;
            end
        end
        else if (empty)
        begin
            result_next.status = mpq_pkg::STATUS_UNDERFLOW;
        end
        else
        begin
            result_next.min_value = cell_value[0];
        end
    end

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            mpq_pkg::REG_CAPACITY: prdata = 32'(capacity_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            capacity_reg <= mpq_pkg::CAPACITY_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            done_reg <= accept;
            if (cfg_write && (paddr[2] == mpq_pkg::REG_CAPACITY))
            begin
                capacity_reg <= pwdata[mpq_pkg::CAP_W-1:0];
            end
        end
    end

    // result payload, qualified by done
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
